@@ rtl/dgte_pkg.sv @@
package dgte_pkg;

    // defaults for the top-level parameters
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int DEPTH_BITS_DEF = 11;

    // fixed field widths
    localparam int CFG_BITS     = 11;
    localparam int ROW_BITS     = 10;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int VERTEX_BITS  = 20;
    localparam int TRI_NUM_BITS = 21;
    localparam int M_DATA_BITS  = ((3 * VERTEX_BITS + TRI_NUM_BITS + 7) / 8) * 8;

    // queue between classifier and emitter
    localparam int QUEUE_DEPTH = 4;

    // apb port
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    // register indexes
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DEPTH_RANGE  = 2'd2;
    localparam logic [1:0] REG_VALID_LIMIT  = 2'd3;

    // reset values of the registers
    localparam logic [CFG_BITS-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [CFG_BITS-1:0] RST_FRAME_HEIGHT = 11'd480;
    localparam logic [CFG_BITS-1:0] RST_DEPTH_RANGE  = 11'd5;
    localparam logic [CFG_BITS-1:0] RST_VALID_LIMIT  = 11'd2046;

    // quad corners
    localparam logic [1:0] CORNER_UL  = 2'd0;
    localparam logic [1:0] CORNER_UP  = 2'd1;
    localparam logic [1:0] CORNER_LT  = 2'd2;
    localparam logic [1:0] CORNER_CUR = 2'd3;

    // triangle kinds, named by corner order
    typedef logic [2:0] tri_kind_t;
    localparam tri_kind_t TRI_012 = 3'd0;
    localparam tri_kind_t TRI_013 = 3'd1;
    localparam tri_kind_t TRI_023 = 3'd2;
    localparam tri_kind_t TRI_123 = 3'd3;
    localparam tri_kind_t TRI_213 = 3'd4;

    // quad case codes (valid bits current, left, upper, upper-left)
    localparam logic [3:0] CASE_NO_CUR = 4'h7;
    localparam logic [3:0] CASE_NO_LT  = 4'hB;
    localparam logic [3:0] CASE_NO_UP  = 4'hD;
    localparam logic [3:0] CASE_NO_UL  = 4'hE;
    localparam logic [3:0] CASE_FULL   = 4'hF;

    // live thresholds from the register file
    typedef struct packed {
        logic [CFG_BITS-1:0] height;
        logic [CFG_BITS-1:0] depth_range;
        logic [CFG_BITS-1:0] valid_limit;
    } thresh_t;

    // one pixel's worth of triangles
    typedef struct packed {
        logic [VERTEX_BITS-1:0]  base;
        tri_kind_t               kind_first;
        tri_kind_t               kind_second;
        logic                    two;
        logic [TRI_NUM_BITS-1:0] num;
    } tri_entry_t;

    // corner codes of a triangle kind, vertex a in the low bits
    function automatic logic [5:0] tri_corners(input tri_kind_t kind);
        logic [5:0] c;
        unique case (kind)
            TRI_012: c = {CORNER_LT,  CORNER_UP,  CORNER_UL};
            TRI_013: c = {CORNER_CUR, CORNER_UP,  CORNER_UL};
            TRI_023: c = {CORNER_CUR, CORNER_LT,  CORNER_UL};
            TRI_123: c = {CORNER_CUR, CORNER_LT,  CORNER_UP};
            TRI_213: c = {CORNER_CUR, CORNER_UP,  CORNER_LT};
            default: c = {CORNER_UL,  CORNER_UL,  CORNER_UL};
        endcase
        return c;
    endfunction

    // index offset of a corner from the upper-left index
    function automatic logic [VERTEX_BITS-1:0] corner_offset(input logic [1:0] corner,
                                                             input logic [VERTEX_BITS-1:0] w);
        logic [VERTEX_BITS-1:0] off;
        unique case (corner)
            CORNER_UL:  off = '0;
            CORNER_UP:  off = VERTEX_BITS'(1);
            CORNER_LT:  off = w;
            CORNER_CUR: off = w + VERTEX_BITS'(1);
            default:    off = '0;
        endcase
        return off;
    endfunction

endpackage

@@ rtl/dgte_ram.sv @@
module dgte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/dgte_front.sv @@
module dgte_front #(
    parameter int MAX_WIDTH  = dgte_pkg::MAX_WIDTH_DEF,
    parameter int DEPTH_BITS = dgte_pkg::DEPTH_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [DEPTH_BITS-1:0]        depth,
    input  logic                         frame_start,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] eff_width,
    input  dgte_pkg::thresh_t            thresh,
    input  logic                         q_full,
    output logic                         q_push,
    output dgte_pkg::tri_entry_t         q_entry
);

    import dgte_pkg::*;

    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS = $clog2(MAX_WIDTH + 1);
    localparam int CMP_BITS   = (DEPTH_BITS > CFG_BITS) ? DEPTH_BITS : CFG_BITS;
    localparam int PROD_BITS  = ROW_BITS + WIDTH_BITS;

    // spread of three depths within the range setting
    function automatic logic spread_ok(input logic [DEPTH_BITS-1:0] a,
                                       input logic [DEPTH_BITS-1:0] b,
                                       input logic [DEPTH_BITS-1:0] c,
                                       input logic [CFG_BITS-1:0]   range);
        logic [DEPTH_BITS-1:0] mn;
        logic [DEPTH_BITS-1:0] mx;
        mn = a;
        mx = a;
        if (b < mn) mn = b;
        if (b > mx) mx = b;
        if (c < mn) mn = c;
        if (c > mx) mx = c;
        return CMP_BITS'(mx - mn) <= CMP_BITS'(range);
    endfunction

    // position counters of the next pixel
    logic [COL_BITS-1:0]  col_reg, col_next;
    logic [ROW_BITS-1:0]  row_reg, row_next;

    // classify stage
    logic                    b_valid_reg;
    logic [DEPTH_BITS-1:0]   b_depth_reg;
    logic [COL_BITS-1:0]     b_col_reg;
    logic [ROW_BITS-1:0]     b_row_reg;
    logic                    b_first_reg;
    logic [DEPTH_BITS-1:0]   left_reg;
    logic [DEPTH_BITS-1:0]   ul_reg;
    logic [TRI_NUM_BITS-1:0] count_reg;

    logic                    accept;
    logic                    b_go;
    logic [COL_BITS-1:0]     col_start;
    logic [ROW_BITS:0]       row_start;
    logic [COL_BITS-1:0]     pos_col;
    logic [ROW_BITS:0]       pos_row_w;
    logic [ROW_BITS-1:0]     pos_row;
    logic [WIDTH_BITS-1:0]   col_inc;
    logic [ROW_BITS:0]       row_inc;
    logic [DEPTH_BITS-1:0]   up_depth;

    logic [3:0]              quad_case;
    logic                    quad;
    logic                    ok012, ok013, ok023, ok123;
    logic                    e0, e1;
    tri_kind_t               k0, k1;
    logic                    has_emit;
    logic [1:0]              n_emit;
    logic [TRI_NUM_BITS-1:0] num_first;
    logic [ROW_BITS-1:0]     row_m1;
    logic [PROD_BITS-1:0]    prod;
    logic [31:0]             base_sum;

    assign accept = in_valid && in_ready;

    // position of the incoming pixel, with frame restart and size shrink
    always_comb begin
        col_start = frame_start ? '0 : col_reg;
        row_start = frame_start ? '0 : {1'b0, row_reg};
        if (WIDTH_BITS'(col_start) >= eff_width) begin
            pos_col   = '0;
            pos_row_w = row_start + 1'b1;
        end else begin
            pos_col   = col_start;
            pos_row_w = row_start;
        end
        if (pos_row_w >= thresh.height) begin
            pos_row_w = '0;
        end
        pos_row = pos_row_w[ROW_BITS-1:0];

        // advance past this pixel
        col_inc = WIDTH_BITS'(pos_col) + 1'b1;
        row_inc = {1'b0, pos_row} + 1'b1;
        if (col_inc >= eff_width) begin
            col_next = '0;
            row_next = (row_inc >= thresh.height) ? '0 : row_inc[ROW_BITS-1:0];
        end else begin
            col_next = col_inc[COL_BITS-1:0];
            row_next = pos_row;
        end
    end

    // line store of the previous row
    dgte_ram #(
        .WIDTH (DEPTH_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (pos_col),
        .wr_data (depth),
        .rd_en   (accept),
        .rd_addr (pos_col),
        .rd_data (up_depth)
    );

    // quad classification
    always_comb begin
        quad_case[0] = CMP_BITS'(ul_reg)      < CMP_BITS'(thresh.valid_limit);
        quad_case[1] = CMP_BITS'(up_depth)    < CMP_BITS'(thresh.valid_limit);
        quad_case[2] = CMP_BITS'(left_reg)    < CMP_BITS'(thresh.valid_limit);
        quad_case[3] = CMP_BITS'(b_depth_reg) < CMP_BITS'(thresh.valid_limit);
        quad  = (b_col_reg != '0) && (b_row_reg != '0);

        ok012 = spread_ok(ul_reg,   up_depth, left_reg,    thresh.depth_range);
        ok013 = spread_ok(ul_reg,   up_depth, b_depth_reg, thresh.depth_range);
        ok023 = spread_ok(ul_reg,   left_reg, b_depth_reg, thresh.depth_range);
        ok123 = spread_ok(up_depth, left_reg, b_depth_reg, thresh.depth_range);

        e0 = 1'b0;
        e1 = 1'b0;
        k0 = TRI_012;
        k1 = TRI_213;
        unique case (quad_case)
            CASE_NO_CUR: begin e0 = ok012; k0 = TRI_012; end
            CASE_NO_LT:  begin e0 = ok013; k0 = TRI_013; end
            CASE_NO_UP:  begin e0 = ok023; k0 = TRI_023; end
            CASE_NO_UL:  begin e0 = ok123; k0 = TRI_123; end
            CASE_FULL: begin
                e0 = ok012;
                k0 = TRI_012;
                e1 = ok123;
                k1 = TRI_213;
            end
            default: begin
                e0 = 1'b0;
                e1 = 1'b0;
            end
        endcase
        if (!quad) begin
            e0 = 1'b0;
            e1 = 1'b0;
        end
        has_emit = e0 || e1;
        n_emit   = {1'b0, e0} + {1'b0, e1};
    end

    // upper-left vertex index and triangle numbering
    always_comb begin
        row_m1    = b_row_reg - 1'b1;
        prod      = PROD_BITS'(row_m1) * PROD_BITS'(eff_width);
        base_sum  = 32'(prod) + 32'(b_col_reg) - 32'd1;
        num_first = b_first_reg ? '0 : count_reg;

        q_entry.base        = base_sum[VERTEX_BITS-1:0];
        q_entry.kind_first  = e0 ? k0 : k1;
        q_entry.kind_second = k1;
        q_entry.two         = e0 && e1;
        q_entry.num         = num_first;
    end

    // stage handshake
    assign b_go     = b_valid_reg && (!has_emit || !q_full);
    assign in_ready = !b_valid_reg || b_go;
    assign q_push   = b_go && has_emit;

    // counters and classify-stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
            left_reg    <= '0;
            ul_reg      <= '0;
            count_reg   <= '0;
        end else begin
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (in_ready) begin
                b_valid_reg <= in_valid;
            end
            if (b_go) begin
                left_reg  <= b_depth_reg;
                ul_reg    <= up_depth;
                count_reg <= num_first + TRI_NUM_BITS'(n_emit);
            end
        end
    end

    // classify-stage payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            b_depth_reg <= depth;
            b_col_reg   <= pos_col;
            b_row_reg   <= pos_row;
            b_first_reg <= (pos_col == '0) && (pos_row == '0);
        end
    end

endmodule

@@ rtl/dgte_queue.sv @@
module dgte_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  dgte_pkg::tri_entry_t push_entry,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output dgte_pkg::tri_entry_t head_entry
);

    import dgte_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    tri_entry_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] head_reg, head_next;
    logic [PTR_BITS-1:0] tail_reg, tail_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[head_reg];

    // pointer wrap and fill count
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push) begin
            tail_next = (tail_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (pop) begin
            head_next = (head_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[tail_reg] <= push_entry;
        end
    end

endmodule

@@ rtl/dgte_back.sv @@
module dgte_back #(
    parameter int MAX_WIDTH = dgte_pkg::MAX_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]    eff_width,
    input  logic                              head_valid,
    input  dgte_pkg::tri_entry_t              head_entry,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [dgte_pkg::M_DATA_BITS-1:0]  out_data,
    output logic                              out_last
);

    import dgte_pkg::*;

    logic                          phase_reg, phase_next;
    logic                          valid_reg, valid_next;
    logic [M_DATA_BITS-1:0]        data_reg;
    logic                          last_reg;

    logic                          load;
    logic                          take;
    tri_kind_t                     kind_sel;
    logic [5:0]                    corners;
    logic [VERTEX_BITS-1:0]        w20;
    logic [VERTEX_BITS-1:0]        vtx_a, vtx_b, vtx_c;
    logic [TRI_NUM_BITS-1:0]       num_sel;
    logic                          last_sel;

    assign load = !valid_reg || out_ready;
    assign take = load && head_valid;
    assign pop  = take && (phase_reg || !head_entry.two);

    // expand the head entry into one triangle
    always_comb begin
        kind_sel = phase_reg ? head_entry.kind_second : head_entry.kind_first;
        corners  = tri_corners(kind_sel);
        w20      = VERTEX_BITS'(eff_width);
        vtx_a    = head_entry.base + corner_offset(corners[1:0], w20);
        vtx_b    = head_entry.base + corner_offset(corners[3:2], w20);
        vtx_c    = head_entry.base + corner_offset(corners[5:4], w20);
        num_sel  = phase_reg ? head_entry.num + 1'b1 : head_entry.num;
        last_sel = phase_reg || !head_entry.two;

        phase_next = take ? (!phase_reg && head_entry.two) : phase_reg;
        valid_next = load ? head_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (take) begin
            data_reg <= M_DATA_BITS'({num_sel, vtx_c, vtx_b, vtx_a});
            last_reg <= last_sel;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_last  = last_reg;

endmodule

@@ rtl/depth_grid_triangle_emitter.sv @@
// depth grid triangle emitter: raster depth pixels in, mesh triangles out
// datapath: classify stage register, then triangle queue, then output register driving m_
// throughput: one pixel per cycle while the triangle queue has room; the emitter's single
//   output register gives one triangle per cycle while m_tready is high, a quad's two in turn
// reset: synchronous active-low aresetn clears counters, queue and registers to defaults;
//   the row store is not cleared and needs no clearing pass
module depth_grid_triangle_emitter #(
    parameter int MAX_WIDTH  = dgte_pkg::MAX_WIDTH_DEF,
    parameter int DEPTH_BITS = dgte_pkg::DEPTH_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input pixel stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((DEPTH_BITS+7)/8)*8-1:0]     s_tdata,  // depth
    input  logic                                s_tuser,  // frame_start
    // triangle stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dgte_pkg::M_DATA_BITS-1:0]    m_tdata,  // vertex_a, vertex_b, vertex_c,
                                                          // triangle_number
    output logic                                m_tlast,  // last_of_pixel
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dgte_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [dgte_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [dgte_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);

    import dgte_pkg::*;

    localparam int WIDTH_BITS = $clog2(MAX_WIDTH + 1);

    logic [CFG_BITS-1:0]   frame_width_reg;
    logic [CFG_BITS-1:0]   frame_height_reg;
    logic [CFG_BITS-1:0]   depth_range_reg;
    logic [CFG_BITS-1:0]   valid_limit_reg;

    logic                  cfg_wr;
    logic [1:0]            reg_idx;
    logic [31:0]           fw32, fh32;
    logic [WIDTH_BITS-1:0] eff_width;
    thresh_t               thresh;

    logic                  q_full;
    logic                  q_push;
    tri_entry_t            q_entry;
    logic                  q_pop;
    logic                  head_valid;
    tri_entry_t            head_entry;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            depth_range_reg  <= RST_DEPTH_RANGE;
            valid_limit_reg  <= RST_VALID_LIMIT;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[CFG_BITS-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[CFG_BITS-1:0];
                REG_DEPTH_RANGE:  depth_range_reg  <= pwdata[CFG_BITS-1:0];
                REG_VALID_LIMIT:  valid_limit_reg  <= pwdata[CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_BITS'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_BITS'(frame_height_reg);
            REG_DEPTH_RANGE:  prdata = APB_DATA_BITS'(depth_range_reg);
            REG_VALID_LIMIT:  prdata = APB_DATA_BITS'(valid_limit_reg);
            default:          prdata = '0;
        endcase
    end

    // frame size clamped to what the line store and row counter hold
    always_comb begin
        fw32 = 32'(frame_width_reg);
        fh32 = 32'(frame_height_reg);
        if (fw32 < 32'd2) begin
            fw32 = 32'd2;
        end else if (fw32 > 32'(MAX_WIDTH)) begin
            fw32 = 32'(MAX_WIDTH);
        end
        if (fh32 < 32'd2) begin
            fh32 = 32'd2;
        end else if (fh32 > 32'(HEIGHT_LIMIT)) begin
            fh32 = 32'(HEIGHT_LIMIT);
        end
        eff_width          = fw32[WIDTH_BITS-1:0];
        thresh.height      = fh32[CFG_BITS-1:0];
        thresh.depth_range = depth_range_reg;
        thresh.valid_limit = valid_limit_reg;
    end

    dgte_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .depth       (s_tdata[DEPTH_BITS-1:0]),
        .frame_start (s_tuser),
        .eff_width   (eff_width),
        .thresh      (thresh),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_entry)
    );

    dgte_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    dgte_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .eff_width  (eff_width),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import dgte_pkg::*;

    localparam int DW             = DEPTH_BITS_DEF;
    localparam int SW             = ((DW + 7) / 8) * 8;
    localparam int DMAX           = (1 << DW) - 1;
    localparam int VB             = VERTEX_BITS;
    localparam int NB             = TRI_NUM_BITS;
    localparam int IDLE_PCT       = 23;
    localparam int STALL_CYCLES   = 400;
    localparam int STALL_AFTER    = 80;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int REPORT_MAX     = 10;

    typedef struct packed {
        logic [VB-1:0] va;
        logic [VB-1:0] vb;
        logic [VB-1:0] vc;
        logic [NB-1:0] num;
        logic          last;
    } tri_t;

    typedef struct packed {
        logic [DW-1:0] depth;
        logic          start;
    } pixel_t;

    logic                     aclk;
    logic                     aresetn  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [SW-1:0]            s_tdata  = '0;
    logic                     s_tuser  = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [M_DATA_BITS-1:0]   m_tdata;
    logic                     m_tlast;
    logic                     psel     = 1'b0;
    logic                     penable  = 1'b0;
    logic                     pwrite   = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr    = '0;
    logic [APB_DATA_BITS-1:0] pwdata   = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    depth_grid_triangle_emitter #(
        .MAX_WIDTH  (MAX_WIDTH_DEF),
        .DEPTH_BITS (DW)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // pixels waiting to be sent, triangles waiting to come out
    pixel_t      pixel_q[$];
    tri_t        tri_expect_q[$];
    pixel_t      cur_px;
    int unsigned px_total = 0;
    int unsigned px_done  = 0;
    int unsigned tri_seen = 0;
    int unsigned fail_cnt = 0;
    int unsigned quiet_cycles = 0;
    int unsigned stall_left = 0;
    bit          stall_done = 1'b0;
    tri_t        got_tri;
    tri_t        want_tri;

    // mirror of the mesh state and registers
    logic [DW-1:0]       line_buf [MAX_WIDTH_DEF];
    logic [DW-1:0]       left_d;
    logic [DW-1:0]       upleft_d;
    int unsigned         col_pos;
    int unsigned         row_pos;
    logic [NB-1:0]       tri_cnt;
    logic [CFG_BITS-1:0] cfg_w;
    logic [CFG_BITS-1:0] cfg_h;
    logic [CFG_BITS-1:0] cfg_range;
    logic [CFG_BITS-1:0] cfg_limit;

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // advance the mesh by one pixel and queue the triangles it closes
    function automatic void mesh_step(input pixel_t px);
        int unsigned   w;
        int unsigned   h;
        int unsigned   base;
        int unsigned   lo;
        int unsigned   hi;
        int unsigned   off [4];
        logic [DW-1:0] up;
        logic [DW-1:0] dep [4];
        logic [1:0]    crn [2][3];
        logic [3:0]    qcase;
        int            ntri;
        int            n;
        tri_t          found [2];

        w = (cfg_w < 2) ? 2 : (cfg_w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : cfg_w;
        h = (cfg_h < 2) ? 2 : (cfg_h > HEIGHT_LIMIT) ? HEIGHT_LIMIT : cfg_h;

        // position of this pixel, including a shrunk size
        if (px.start) begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        if (col_pos == 0 && row_pos == 0) tri_cnt = '0;

        up = line_buf[col_pos];
        n = 0;

        // quad closed by this pixel
        if (col_pos >= 1 && row_pos >= 1) begin
            base = (row_pos - 1) * w + (col_pos - 1);
            dep[CORNER_UL]  = upleft_d;
            dep[CORNER_UP]  = up;
            dep[CORNER_LT]  = left_d;
            dep[CORNER_CUR] = px.depth;
            off[CORNER_UL]  = 0;
            off[CORNER_UP]  = 1;
            off[CORNER_LT]  = w;
            off[CORNER_CUR] = w + 1;
            for (int k = 0; k < 4; k++) qcase[k] = (dep[k] < cfg_limit);

            ntri = 1;
            case (qcase)
                CASE_NO_CUR: crn[0] = '{CORNER_UL, CORNER_UP, CORNER_LT};
                CASE_NO_LT:  crn[0] = '{CORNER_UL, CORNER_UP, CORNER_CUR};
                CASE_NO_UP:  crn[0] = '{CORNER_UL, CORNER_LT, CORNER_CUR};
                CASE_NO_UL:  crn[0] = '{CORNER_UP, CORNER_LT, CORNER_CUR};
                CASE_FULL: begin
                    crn[0] = '{CORNER_UL, CORNER_UP, CORNER_LT};
                    crn[1] = '{CORNER_LT, CORNER_UP, CORNER_CUR};
                    ntri = 2;
                end
                default: ntri = 0;
            endcase

            // keep only triangles with a small depth spread
            for (int t = 0; t < ntri; t++) begin
                lo = dep[crn[t][0]];
                hi = dep[crn[t][0]];
                for (int k = 1; k < 3; k++) begin
                    if (dep[crn[t][k]] < lo) lo = dep[crn[t][k]];
                    if (dep[crn[t][k]] > hi) hi = dep[crn[t][k]];
                end
                if (hi - lo <= cfg_range) begin
                    found[n].va   = VB'(base + off[crn[t][0]]);
                    found[n].vb   = VB'(base + off[crn[t][1]]);
                    found[n].vc   = VB'(base + off[crn[t][2]]);
                    found[n].num  = tri_cnt;
                    found[n].last = 1'b0;
                    tri_cnt++;
                    n++;
                end
            end
            if (n > 0) found[n-1].last = 1'b1;
            for (int i = 0; i < n; i++) tri_expect_q.push_back(found[i]);
        end

        upleft_d = up;
        left_d = px.depth;
        line_buf[col_pos] = px.depth;
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endfunction

    // depth near a running base, sometimes invalid or fully random
    function automatic logic [DW-1:0] pick_depth(input int unsigned base,
                                                 input int unsigned rng,
                                                 input int unsigned lim);
        int unsigned r;
        int unsigned spr;
        int unsigned d;

        r = $urandom_range(0, 99);
        if (r < 65) begin
            spr = (rng > 30) ? 30 : rng;
            d = base + $urandom_range(0, spr + 1);
            if (d > DMAX) d = DMAX;
        end else if (r < 80) begin
            d = $urandom_range(lim, DMAX);
        end else begin
            d = $urandom_range(0, DMAX);
        end
        return d[DW-1:0];
    endfunction

    // register write, setup then access
    task automatic cfg_write(input logic [1:0] idx, input int unsigned val);
        logic [APB_DATA_BITS-1:0] word;

        word = $urandom;
        word[CFG_BITS-1:0] = val[CFG_BITS-1:0];
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  cfg_w     = val[CFG_BITS-1:0];
            REG_FRAME_HEIGHT: cfg_h     = val[CFG_BITS-1:0];
            REG_DEPTH_RANGE:  cfg_range = val[CFG_BITS-1:0];
            REG_VALID_LIMIT:  cfg_limit = val[CFG_BITS-1:0];
            default: ;
        endcase
    endtask

    // wait until every pixel is in and every triangle is out
    task automatic settle();
        while (px_done != px_total || tri_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h,
                             input int unsigned rng, input int unsigned lim);
        settle();
        cfg_write(REG_FRAME_WIDTH, w);
        cfg_write(REG_FRAME_HEIGHT, h);
        cfg_write(REG_DEPTH_RANGE, rng);
        cfg_write(REG_VALID_LIMIT, lim);
    endtask

    // one setting with a stream of random pixels
    task automatic run_phase(input int unsigned w, input int unsigned h,
                             input int unsigned rng, input int unsigned lim,
                             input int unsigned count, input bit with_start);
        int unsigned base;
        pixel_t      px;

        set_frame(w, h, rng, lim);
        base = 0;
        for (int unsigned i = 0; i < count; i++) begin
            if (i == 0 || $urandom_range(0, 99) < 5)
                base = (lim > 40) ? $urandom_range(0, lim - 40) : 0;
            px.depth = pick_depth(base, rng, lim);
            px.start = (i == 0 && with_start) || ($urandom_range(0, 99) < 2);
            pixel_q.push_back(px);
        end
        px_total += count;
    endtask

    // pixel driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                mesh_step(cur_px);
                px_done++;
            end
            if (!s_tvalid || s_tready) begin
                if (pixel_q.size() > 0 &&
                    ((px_done >= 200 && px_done < 500) ||
                     $urandom_range(0, 99) >= IDLE_PCT)) begin
                    cur_px = pixel_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(SW - DW){1'b0}}, cur_px.depth};
                    s_tuser  <= cur_px.start;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // triangle monitor and receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_tri.va   = m_tdata[VB-1:0];
                got_tri.vb   = m_tdata[2*VB-1:VB];
                got_tri.vc   = m_tdata[3*VB-1:2*VB];
                got_tri.num  = m_tdata[3*VB+NB-1:3*VB];
                got_tri.last = m_tlast;
                tri_seen++;
                if (tri_expect_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_MAX)
                        $display("unexpected triangle: a=%0d b=%0d c=%0d num=%0d last=%0b",
                                 got_tri.va, got_tri.vb, got_tri.vc, got_tri.num,
                                 got_tri.last);
                end else begin
                    want_tri = tri_expect_q.pop_front();
                    if (got_tri !== want_tri) begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_MAX) begin
                            $display("triangle mismatch: expected a=%0d b=%0d c=%0d num=%0d last=%0b",
                                     want_tri.va, want_tri.vb, want_tri.vc, want_tri.num,
                                     want_tri.last);
                            $display("                   actual   a=%0d b=%0d c=%0d num=%0d last=%0b",
                                     got_tri.va, got_tri.vb, got_tri.vc, got_tri.num,
                                     got_tri.last);
                        end
                    end
                end
            end

            // one long hold-off so the block backs up into the pixel side
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!stall_done && tri_seen >= STALL_AFTER) begin
                stall_done = 1'b1;
                stall_left = STALL_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (tri_seen >= 120 && tri_seen < 220) ||
                            ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // watchdog on transfers
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        int unsigned dir_depth [24];
        bit          dir_start [24];
        pixel_t      px;
        int unsigned rng;
        int unsigned lim;

        dir_depth = '{100, 105, 103, 100, 105, 2047, 2046, 101,
                      106, 0, 2045, 1000, 7, 7, 2047, 50,
                      50, 50, 50, 51, 56, 1024, 1, 1023};
        dir_start = '{1, 0, 0, 0, 0, 0, 0, 0,
                      0, 0, 0, 0, 0, 0, 0, 1,
                      0, 0, 0, 0, 0, 0, 0, 0};
        cfg_w     = RST_FRAME_WIDTH;
        cfg_h     = RST_FRAME_HEIGHT;
        cfg_range = RST_DEPTH_RANGE;
        cfg_limit = RST_VALID_LIMIT;
        left_d    = '0;
        upleft_d  = '0;
        col_pos   = 0;
        row_pos   = 0;
        tri_cnt   = '0;
        foreach (line_buf[i]) line_buf[i] = '0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // small frame: every quad case, spread at and over the range,
        // validity at the limit, frame wrap and a restart mid-frame
        set_frame(3, 4, 5, 2046);
        foreach (dir_depth[i]) begin
            px.depth = dir_depth[i][DW-1:0];
            px.start = dir_start[i];
            pixel_q.push_back(px);
        end
        px_total += 24;

        // width over the line store, saturated; fills the first columns of the store
        run_phase(2047, 2, 3, 1500, 40, 1'b1);
        run_phase(5, 3, 5, 2046, 120, 1'b1);
        // sizes below the minimum, zero range, nothing valid
        run_phase(0, 0, 0, 2047, 60, 1'b1);
        run_phase(1, 1, 2047, 0, 40, 1'b0);
        // tallest frame, widest range
        run_phase(9, 2047, 2047, 2047, 100, 1'b0);

        // random settings, often changed mid-frame
        for (int p = 0; p < 6; p++) begin
            case ($urandom_range(0, 2))
                0:       rng = $urandom_range(0, 2);
                1:       rng = $urandom_range(3, 12);
                default: rng = $urandom_range(13, DMAX);
            endcase
            lim = $urandom_range(0, 1) ? 2046 : $urandom_range(0, DMAX);
            run_phase($urandom_range(2, 12), $urandom_range(2, 6), rng, lim, 55,
                      $urandom_range(0, 1));
        end

        settle();
        if (fail_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
